@@ hw/rtl/sfd_pkg.sv @@
`timescale 1ns / 1ps

package sfd_pkg;

  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int COUNT_W = 6;
  localparam int MIN_W   = 7;
  localparam int IDX_W   = 2;

  // event codes
  localparam logic [KIND_W-1:0] EV_CONTENT  = 2'd0;
  localparam logic [KIND_W-1:0] EV_BAD_TAIL = 2'd1;
  localparam logic [KIND_W-1:0] EV_BAD_LEN  = 2'd2;

  // register indexes
  localparam logic [IDX_W-1:0] CFG_HEADER  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_TAIL    = 2'd1;
  localparam logic [IDX_W-1:0] CFG_MIN_CNT = 2'd2;

  localparam logic [MIN_W-1:0] MIN_CNT_RST = 7'd5;

  // frame layout
  localparam int POS_LEN      = 1;
  localparam int POS_CMD      = 3;
  localparam int POS_DATA     = 4;
  localparam int HDR_OVERHEAD = 2;
  localparam int LEN_MIN      = 3;
  localparam int MAX_PAYLOAD  = 59;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  cmd;
    logic [COUNT_W-1:0] count;
  } job_t;

endpackage

@@ hw/rtl/sfd_front.sv @@
`timescale 1ns / 1ps

module sfd_front import sfd_pkg::*; #(
  parameter int FRAME_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [BYTE_W-1:0]              in_rx_byte,
  output logic                           in_stall,
  input  logic [BYTE_W-1:0]              header_value,
  input  logic [BYTE_W-1:0]              tail_value,
  input  logic [MIN_W-1:0]               min_frame_count,
  input  logic                           q_full,
  input  logic                           frame_done,
  output logic                           push,
  output job_t                           push_job,
  output logic                           mem_we,
  output logic [$clog2(FRAME_DEPTH)-1:0] mem_addr,
  output logic [BYTE_W-1:0]              mem_data
);

  localparam int AW   = $clog2(FRAME_DEPTH);
  localparam int CW   = $clog2(FRAME_DEPTH + 1);
  localparam int CMPW = (CW > 9) ? CW + 1 : 10;

  logic [CW-1:0]     fill_r, fill_nxt;
  logic [BYTE_W-1:0] len_r, len_nxt;
  logic [BYTE_W-1:0] cmd_r, cmd_nxt;
  logic [BYTE_W-1:0] tail_r, tail_nxt;
  logic              lock_r, lock_nxt;

  logic              hit;
  logic [BYTE_W-1:0] len_cur, tail_cur;
  logic [CMPW-1:0]   fc_w, len_w, min_w;
  logic              too_long;

  assign in_stall = lock_r | q_full;
  assign hit      = in_valid & ~in_stall;

  assign len_cur  = (fill_r == CW'(POS_LEN)) ? in_rx_byte : len_r;
  assign len_w    = CMPW'(len_cur);
  assign fc_w     = CMPW'(fill_r) + CMPW'(1);
  assign min_w    = CMPW'(min_frame_count);
  assign tail_cur = (CMPW'(fill_r) == len_w + CMPW'(1)) ? in_rx_byte : tail_r;
  assign too_long = (len_w + CMPW'(HDR_OVERHEAD) > CMPW'(FRAME_DEPTH)) ||
                    (len_w > CMPW'(MAX_PAYLOAD + LEN_MIN));

  assign mem_addr = fill_r[AW-1:0];
  assign mem_data = in_rx_byte;

  always_comb begin
    fill_nxt = fill_r;
    len_nxt  = len_r;
    cmd_nxt  = cmd_r;
    tail_nxt = tail_r;
    lock_nxt = lock_r & ~frame_done;
    push     = 1'b0;
    push_job = '0;
    mem_we   = 1'b0;
    if (hit && !(fill_r == '0 && in_rx_byte != header_value)) begin
      mem_we   = 1'b1;
      len_nxt  = len_cur;
      tail_nxt = tail_cur;
      if (fill_r == CW'(POS_CMD)) begin
        cmd_nxt = in_rx_byte;
      end
      push_job.kind = EV_BAD_LEN;
      priority if (fc_w < CMPW'(2)) begin
        fill_nxt = fc_w[CW-1:0];
      end else if (too_long) begin
        push     = 1'b1;
        fill_nxt = '0;
      end else if (fc_w + CMPW'(1) < min_w) begin
        if (fc_w >= CMPW'(FRAME_DEPTH)) begin
          push     = 1'b1;
          fill_nxt = '0;
        end else begin
          fill_nxt = fc_w[CW-1:0];
        end
      end else if (fc_w < len_w + CMPW'(HDR_OVERHEAD)) begin
        fill_nxt = fc_w[CW-1:0];
      end else if (len_w < CMPW'(LEN_MIN)) begin
        push     = 1'b1;
        fill_nxt = '0;
      end else if (tail_cur != tail_value) begin
        push          = 1'b1;
        push_job.kind = EV_BAD_TAIL;
        fill_nxt      = '0;
      end else begin
        push           = 1'b1;
        push_job.kind  = EV_CONTENT;
        push_job.cmd   = cmd_r;
        push_job.count = COUNT_W'(len_w - CMPW'(LEN_MIN));
        fill_nxt       = '0;
        lock_nxt       = 1'b1;  // hold the store until the frame is read out
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      lock_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      lock_r <= lock_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    cmd_r  <= cmd_nxt;
    tail_r <= tail_nxt;
  end

endmodule

@@ hw/rtl/sfd_queue.sv @@
`timescale 1ns / 1ps

module sfd_queue import sfd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t pop_job,
  output logic full,
  output logic empty
);

  job_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QPTR_W:0]   cnt_r;

  assign full    = (cnt_r == (QPTR_W + 1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_job = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_r <= rd_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_job;
    end
  end

endmodule

@@ hw/rtl/sfd_back.sv @@
`timescale 1ns / 1ps

module sfd_back import sfd_pkg::*; #(
  parameter int FRAME_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           mem_we,
  input  logic [$clog2(FRAME_DEPTH)-1:0] mem_addr,
  input  logic [BYTE_W-1:0]              mem_data,
  input  logic                           q_empty,
  input  job_t                           q_job,
  output logic                           pop,
  output logic                           frame_done,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [KIND_W-1:0]              out_event_kind,
  output logic [BYTE_W-1:0]              out_command_code,
  output logic [BYTE_W-1:0]              out_payload_byte,
  output logic                           out_byte_valid,
  output logic [COUNT_W-1:0]             out_payload_count,
  output logic                           out_last_of_frame
);

  localparam int AW = $clog2(FRAME_DEPTH);

  logic [BYTE_W-1:0] store_r [FRAME_DEPTH];

  logic               valid_r, valid_nxt;
  job_t               job_r, job_nxt;
  logic [COUNT_W-1:0] idx_r, idx_nxt;
  logic               bv_r, bv_nxt;
  logic               last_r, last_nxt;
  logic [BYTE_W-1:0]  pay_r;

  logic               take, rd_en;
  logic [AW-1:0]      rd_addr;

  assign take       = valid_r & ~out_stall;
  assign frame_done = take & last_r & (job_r.kind == EV_CONTENT);

  always_comb begin
    valid_nxt = valid_r;
    job_nxt   = job_r;
    idx_nxt   = idx_r;
    bv_nxt    = bv_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = AW'(POS_DATA);
    if (!valid_r || take) begin
      if (valid_r && !last_r) begin
        // next data word of the same frame
        idx_nxt  = idx_r + COUNT_W'(1);
        rd_en    = 1'b1;
        rd_addr  = AW'(POS_DATA) + AW'(idx_nxt);
        last_nxt = (idx_nxt + COUNT_W'(1) == job_r.count);
      end else if (!q_empty) begin
        pop       = 1'b1;
        valid_nxt = 1'b1;
        job_nxt   = q_job;
        idx_nxt   = '0;
        if (q_job.kind == EV_CONTENT && q_job.count != '0) begin
          rd_en    = 1'b1;
          bv_nxt   = 1'b1;
          last_nxt = (q_job.count == COUNT_W'(1));
        end else begin
          bv_nxt   = 1'b0;
          last_nxt = 1'b1;
        end
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    idx_r  <= idx_nxt;
    bv_r   <= bv_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_r[mem_addr] <= mem_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      pay_r <= store_r[rd_addr];
    end
  end

  assign out_valid         = valid_r;
  assign out_event_kind    = job_r.kind;
  assign out_command_code  = job_r.cmd;
  assign out_payload_byte  = bv_r ? pay_r : '0;
  assign out_byte_valid    = bv_r;
  assign out_payload_count = job_r.count;
  assign out_last_of_frame = last_r;

endmodule

@@ hw/rtl/serial_frame_deframer.sv @@
`timescale 1ns / 1ps
// A frame's first word goes via the job queue and output register once its closing byte is
// taken (idle back end); each further word follows in the cycle after the last is taken.
// Throughput: one input byte per cycle; input stalls while the 4-entry job queue is full
// and from a good frame's closing byte until its last word is taken.
// Reset: synchronous, active low; registers return to header 0, tail 0, min count 5.
// Frame store contents are undefined after reset; no clearing pass.
module serial_frame_deframer import sfd_pkg::*; #(
  parameter int FRAME_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [BYTE_W-1:0]  in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [KIND_W-1:0]  out_event_kind,
  output logic [BYTE_W-1:0]  out_command_code,
  output logic [BYTE_W-1:0]  out_payload_byte,
  output logic               out_byte_valid,
  output logic [COUNT_W-1:0] out_payload_count,
  output logic               out_last_of_frame,
  input  logic               cfg_wr_en,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [BYTE_W-1:0]  cfg_data
);

  localparam int AW = $clog2(FRAME_DEPTH);

  logic [BYTE_W-1:0] header_r, tail_r;
  logic [MIN_W-1:0]  min_cnt_r;

  logic              push, pop, q_full, q_empty, frame_done, mem_we;
  job_t              push_job, pop_job;
  logic [AW-1:0]     mem_addr;
  logic [BYTE_W-1:0] mem_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r  <= '0;
      tail_r    <= '0;
      min_cnt_r <= MIN_CNT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_HEADER:  header_r  <= cfg_data;
        CFG_TAIL:    tail_r    <= cfg_data;
        CFG_MIN_CNT: min_cnt_r <= cfg_data[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  sfd_front #(.FRAME_DEPTH(FRAME_DEPTH)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_rx_byte      (in_rx_byte),
    .in_stall        (in_stall),
    .header_value    (header_r),
    .tail_value      (tail_r),
    .min_frame_count (min_cnt_r),
    .q_full          (q_full),
    .frame_done      (frame_done),
    .push            (push),
    .push_job        (push_job),
    .mem_we          (mem_we),
    .mem_addr        (mem_addr),
    .mem_data        (mem_data)
  );

  sfd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  sfd_back #(.FRAME_DEPTH(FRAME_DEPTH)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .mem_we            (mem_we),
    .mem_addr          (mem_addr),
    .mem_data          (mem_data),
    .q_empty           (q_empty),
    .q_job             (pop_job),
    .pop               (pop),
    .frame_done        (frame_done),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_kind    (out_event_kind),
    .out_command_code  (out_command_code),
    .out_payload_byte  (out_payload_byte),
    .out_byte_valid    (out_byte_valid),
    .out_payload_count (out_payload_count),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule

@@ bench/serial_frame_deframer_tb.sv @@
`timescale 1ns / 1ps

module serial_frame_deframer_tb;
  import sfd_pkg::*;

  localparam int          STORE_DEPTH = 64;
  localparam int unsigned LIMIT       = 200000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned SETTLE      = 8;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  cmd;
    logic [BYTE_W-1:0]  data;
    logic               vld;
    logic [COUNT_W-1:0] count;
    logic               last;
  } frame_word_t;

  // Tracks the frame being assembled and the words it must produce.
  class frame_tracker;
    logic [BYTE_W-1:0] store [STORE_DEPTH];
    int unsigned       fill;
    logic [BYTE_W-1:0] hdr;
    logic [BYTE_W-1:0] tail;
    int unsigned       min_cnt;
    frame_word_t       due_words [$];
    int unsigned       errors;
    int unsigned       words;

    function new();
      fill    = 0;
      hdr     = '0;
      tail    = '0;
      min_cnt = MIN_CNT_RST;
      errors  = 0;
      words   = 0;
    endfunction

    function void set_config(logic [BYTE_W-1:0] h, logic [BYTE_W-1:0] t,
                             logic [MIN_W-1:0] m);
      hdr     = h;
      tail    = t;
      min_cnt = m;
    endfunction

    function void push_drop(logic [KIND_W-1:0] kind);
      frame_word_t w;
      w       = '0;
      w.kind  = kind;
      w.last  = 1'b1;
      fill    = 0;
      due_words.push_back(w);
    endfunction

    function void take_byte(logic [BYTE_W-1:0] b);
      int unsigned len;
      int unsigned n;
      frame_word_t w;
      if (fill == 0 && b != hdr) return;
      store[fill] = b;
      fill++;
      if (fill < 2) return;
      len = store[POS_LEN];
      if (len + HDR_OVERHEAD > STORE_DEPTH ||
          (len >= LEN_MIN && len - LEN_MIN > MAX_PAYLOAD)) begin
        push_drop(EV_BAD_LEN);
        return;
      end
      if (fill + 1 < min_cnt) begin
        if (fill >= STORE_DEPTH) push_drop(EV_BAD_LEN);
        return;
      end
      if (fill < len + HDR_OVERHEAD) return;
      if (len < LEN_MIN) begin
        push_drop(EV_BAD_LEN);
        return;
      end
      if (store[len + 1] != tail) begin
        push_drop(EV_BAD_TAIL);
        return;
      end
      n    = len - LEN_MIN;
      fill = 0;
      w      = '0;
      w.kind = EV_CONTENT;
      w.cmd  = store[POS_CMD];
      if (n == 0) begin
        w.last = 1'b1;
        due_words.push_back(w);
        return;
      end
      for (int i = 0; i < n; i++) begin
        w.data  = store[POS_DATA + i];
        w.vld   = 1'b1;
        w.count = COUNT_W'(n);
        w.last  = (i + 1 == n);
        due_words.push_back(w);
      end
    endfunction

    task report_mismatch(string what);
      if (errors < 40) $display("MISMATCH @%0t: %s", $realtime, what);
      errors++;
    endtask

    task cmp(string field, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] want);
      if (got !== want)
        report_mismatch($sformatf("word %0d %s: got %0h, expected %0h",
                                  words, field, got, want));
    endtask

    task match_word(frame_word_t got);
      frame_word_t want;
      if (due_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word kind=%0d cmd=%0h data=%0h",
                                  got.kind, got.cmd, got.data));
        return;
      end
      want = due_words.pop_front();
      cmp("event_kind", got.kind, want.kind);
      cmp("command_code", got.cmd, want.cmd);
      cmp("payload_byte", got.data, want.data);
      cmp("byte_valid", got.vld, want.vld);
      cmp("payload_count", got.count, want.count);
      cmp("last_of_frame", got.last, want.last);
      words++;
    endtask
  endclass

  logic               clk;
  logic               rst_n             = 1'b0;
  logic               in_valid          = 1'b0;
  logic               in_stall;
  logic [BYTE_W-1:0]  in_rx_byte        = '0;
  logic               out_valid;
  logic               out_stall         = 1'b0;
  logic [KIND_W-1:0]  out_event_kind;
  logic [BYTE_W-1:0]  out_command_code;
  logic [BYTE_W-1:0]  out_payload_byte;
  logic               out_byte_valid;
  logic [COUNT_W-1:0] out_payload_count;
  logic               out_last_of_frame;
  logic               cfg_wr_en         = 1'b0;
  logic [IDX_W-1:0]   cfg_index         = CFG_HEADER;
  logic [BYTE_W-1:0]  cfg_data          = '0;

  frame_tracker sb;
  frame_word_t  seen_word;
  int unsigned  cycles      = 0;
  int unsigned  frame_items = 0;
  int unsigned  tx_draws    = 0;
  bit           tx_calm     = 1'b0;
  int unsigned  rx_draws    = 0;
  bit           rx_calm     = 1'b0;
  bit           long_hold   = 1'b0;

  serial_frame_deframer u_dut (.*);

  assign seen_word = {out_event_kind, out_command_code, out_payload_byte,
                      out_byte_valid, out_payload_count, out_last_of_frame};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) sb.match_word(seen_word);
  end

  // wait draw with runs of back-to-back traffic now and then
  function automatic int unsigned draw_wait(inout int unsigned draws, inout bit calm);
    if (draws % 16 == 0) calm = ($urandom_range(0, 2) == 0);
    draws++;
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  // result side: random stall (possibly none) before each word, one long hold on request
  initial begin
    int unsigned n;
    forever begin
      if (long_hold) begin
        n         = LONG_HOLD;
        long_hold = 1'b0;
      end else begin
        n = draw_wait(rx_draws, rx_calm);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  task automatic send_byte(logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = draw_wait(tx_draws, tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.take_byte(b);
  endtask

  // header, length, ignored byte, command, data, tail, then filler while the minimum
  // count holds the check back; header and length only if the frame overflows the store
  task automatic send_frame(int unsigned len, bit bad_tail);
    int unsigned       total;
    logic [BYTE_W-1:0] b;
    total = len + HDR_OVERHEAD;
    if (len + HDR_OVERHEAD > STORE_DEPTH) total = 2;
    else if (sb.min_cnt > 0 && sb.min_cnt - 1 > total) total = sb.min_cnt - 1;
    for (int i = 0; i < total; i++) begin
      if (i == 0) b = sb.hdr;
      else if (i == POS_LEN) b = len[BYTE_W-1:0];
      else if (i == len + 1)
        b = bad_tail ? sb.tail ^ BYTE_W'(1 + $urandom_range(0, 254)) : sb.tail;
      else b = BYTE_W'($urandom);
      send_byte(b);
    end
    frame_items += total;
  endtask

  // finish any frame left open by noise
  task automatic close_frame();
    while (sb.fill != 0) send_byte(BYTE_W'($urandom));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.due_words.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(logic [BYTE_W-1:0] h, logic [BYTE_W-1:0] t,
                           logic [MIN_W-1:0] m);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_HEADER;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= CFG_TAIL;
    cfg_data  <= t;
    @(posedge clk);
    cfg_index <= CFG_MIN_CNT;
    cfg_data  <= {1'b0, m};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_config(h, t, m);
  endtask

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(LEN_MIN, 8);
    if (r < 9) return $urandom_range(9, 30);
    return $urandom_range(31, STORE_DEPTH - HDR_OVERHEAD);
  endfunction

  task automatic run_phase(logic [BYTE_W-1:0] h, logic [BYTE_W-1:0] t,
                           logic [MIN_W-1:0] m, int unsigned budget,
                           bit big_first, bit hold, bit pause);
    int unsigned start;
    int unsigned pick;
    bit          paused;
    settle();
    cfg_write(h, t, m);
    start  = frame_items;
    paused = 1'b0;
    if (hold) long_hold = 1'b1;
    if (big_first) send_frame(STORE_DEPTH - HDR_OVERHEAD, 1'b0);
    while (frame_items - start < budget) begin
      if (pause && !paused && frame_items - start >= budget / 2) begin
        paused   = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.due_words.size() != 0);
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        send_frame(pick_len(), 1'b0);
      end else if (pick == 7) begin
        send_frame(pick_len(), 1'b1);
      end else if (pick == 8) begin
        if ($urandom_range(0, 1)) send_frame($urandom_range(0, LEN_MIN - 1), 1'b0);
        else send_frame($urandom_range(STORE_DEPTH - 1, 255), 1'b0);
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom));
      end
    end
    close_frame();
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers at reset values: header 0, tail 0, minimum count 5
    send_frame(3, 1'b0);
    send_frame(4, 1'b1);
    settle();

    cfg_write(8'hA5, 8'h5A, 7'd0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(3, 1'b0);
    send_frame(0, 1'b0);
    send_frame(1, 1'b0);
    send_frame(2, 1'b0);
    send_frame(STORE_DEPTH - 1, 1'b0);
    send_frame(255, 1'b0);
    send_frame(5, 1'b0);
    send_frame(4, 1'b1);
    close_frame();

    run_phase(8'hA5, 8'h5A, 7'd0, 70, 1'b1, 1'b1, 1'b0);
    run_phase(8'h00, 8'hFF, 7'd64, 40, 1'b0, 1'b0, 1'b0);
    run_phase(8'hFF, 8'h00, 7'd63, 40, 1'b0, 1'b0, 1'b0);
    run_phase(BYTE_W'($urandom), BYTE_W'($urandom), MIN_W'($urandom_range(0, 64)),
              40, 1'b0, 1'b0, 1'b1);
    run_phase(8'h7E, 8'h7E, 7'd1, 40, 1'b0, 1'b0, 1'b0);
    run_phase(BYTE_W'($urandom), BYTE_W'($urandom), 7'd5, 30, 1'b0, 1'b0, 1'b0);

    settle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.due_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
